// ----- src/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg
// Types, codes and coil tables shared by the stepper phase sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

    // channel select width; the block serves at most two motors
    localparam int CH_W = 1;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_START  = 2'd1;
    localparam logic [1:0] FUNC_STOP   = 2'd2;
    localparam logic [1:0] FUNC_PERIOD = 2'd3;

    localparam logic [1:0] MODE_WAVE = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_HALF = 2'd2;

    localparam logic [2:0] TOP_HALF = 3'd7;
    localparam logic [2:0] TOP_FOUR = 3'd3;

    localparam logic [3:0] WAVE_TAB [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [3:0] FULL_TAB [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
    localparam logic [3:0] HALF_TAB [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                           4'h4, 4'hC, 4'h8, 4'h9};

    typedef enum logic {
        ST_IDLE,
        ST_TICK
    } t_state;

    typedef struct packed {
        logic            apply;   // command item accepted this cycle
        logic            visit;   // process channel chan of a tick
        logic [CH_W-1:0] chan;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;           // result register can take a new item
    } t_dp_stat;

    function automatic logic [2:0] top_of(input logic [1:0] mode);
        return (mode == MODE_HALF) ? TOP_HALF : TOP_FOUR;
    endfunction

    // code 3 falls back to full step
    function automatic logic [3:0] pattern_of(input logic [1:0] mode,
                                              input logic [2:0] idx);
        logic [3:0] pat;
        case (mode)
            MODE_WAVE: pat = WAVE_TAB[idx[1:0]];
            MODE_HALF: pat = HALF_TAB[idx];
            default:   pat = FULL_TAB[idx[1:0]];
        endcase
        return pat;
    endfunction

endpackage

// ----- src/sps_if.sv -----
// ----------------------------------------------------------------------------
// sps_if
// Valid/ready channels for command/tick items and per-channel results.
// ----------------------------------------------------------------------------
interface sps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        unit;
    logic [31:0] step_count;
    logic        direction;
    logic [31:0] step_period;

    modport source (output valid, func, unit, step_count, direction, step_period,
                    input ready);
    modport sink   (input valid, func, unit, step_count, direction, step_period,
                    output ready);
endinterface

interface sps_out_if;
    logic       valid;
    logic       ready;
    logic       channel;
    logic [3:0] coils;
    logic       stepped;
    logic       busy_res;
    logic       last;

    modport source (output valid, channel, coils, stepped, busy_res, last,
                    input ready);
    modport sink   (input valid, channel, coils, stepped, busy_res, last,
                    output ready);
endinterface

// ----- src/sps_regs.sv -----
// ----------------------------------------------------------------------------
// sps_regs
// APB register file holding the stepping mode of each motor.
// ----------------------------------------------------------------------------
module sps_regs
    import sps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [1:0]  o_mode0,
    output logic [1:0]  o_mode1
);

    logic [1:0] r_mode0;
    logic [1:0] r_mode1;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode0 <= MODE_FULL;
            r_mode1 <= MODE_FULL;
        end else if (w_wr) begin
            if (paddr[2]) begin
                r_mode1 <= pwdata[1:0];
            end else begin
                r_mode0 <= pwdata[1:0];
            end
        end
    end

    assign prdata  = {30'd0, (paddr[2] ? r_mode1 : r_mode0)};
    assign o_mode0 = r_mode0;
    assign o_mode1 = r_mode1;

endmodule

// ----- src/sps_ctrl.sv -----
// ----------------------------------------------------------------------------
// sps_ctrl
// Sequencer: takes items, walks tick channels one per cycle while out_free.
// ----------------------------------------------------------------------------
module sps_ctrl
    import sps_pkg::*;
#(
    parameter int MOTORS = 2
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_func,
    output logic       o_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    t_state          r_state;
    t_state          n_state;
    logic [CH_W-1:0] r_chan;
    logic [CH_W-1:0] n_chan;
    logic            w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chan  <= '0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_chan      = r_chan;
        o_ready     = 1'b0;
        o_cmd.apply = 1'b0;
        o_cmd.visit = 1'b0;
        o_cmd.chan  = r_chan;
        w_acc       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                w_acc   = i_valid;
                if (w_acc) begin
                    if (i_func == FUNC_TICK) begin
                        n_state = ST_TICK;
                        n_chan  = '0;
                    end else begin
                        o_cmd.apply = 1'b1;
                    end
                end
            end
            ST_TICK: begin
                if (i_stat.out_free) begin
                    o_cmd.visit = 1'b1;
                    if (r_chan == CH_W'(MOTORS - 1)) begin
                        n_state = ST_IDLE;
                        n_chan  = '0;
                    end else begin
                        n_chan = r_chan + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_chan  = '0;
            end
        endcase
    end

endmodule

// ----- src/sps_dp.sv -----
// ----------------------------------------------------------------------------
// sps_dp
// Per-channel step state, coil lookup and the result register.
// ----------------------------------------------------------------------------
module sps_dp
    import sps_pkg::*;
#(
    parameter int MOTORS = 2
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [1:0]  i_func,
    input  logic        i_unit,
    input  logic [31:0] i_step_count,
    input  logic        i_direction,
    input  logic [31:0] i_step_period,
    input  logic [1:0]  i_mode0,
    input  logic [1:0]  i_mode1,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_channel,
    output logic [3:0]  o_coils,
    output logic        o_stepped,
    output logic        o_busy,
    output logic        o_last
);

    logic [31:0] r_rem    [MOTORS];
    logic [31:0] r_ticks  [MOTORS];
    logic [31:0] r_period [MOTORS];
    logic [2:0]  r_phase  [MOTORS];
    logic        r_dir    [MOTORS];
    logic [3:0]  r_hold   [MOTORS];

    logic        w_step  [MOTORS];
    logic [3:0]  w_coils [MOTORS];
    logic        w_busy  [MOTORS];

    logic        r_out_valid;
    logic        r_out_chan;
    logic [3:0]  r_out_coils;
    logic        r_out_step;
    logic        r_out_busy;
    logic        r_out_last;

    logic        n_coils_step;
    logic [3:0]  n_coils;
    logic        n_busy;

    for (genvar c = 0; c < MOTORS; c++) begin : g_ch
        logic [1:0] w_mode;
        logic [2:0] w_top;
        logic [2:0] w_idx;
        logic [2:0] w_nidx;
        logic [3:0] w_pat;
        logic       w_sel;
        logic       w_hit;

        assign w_mode = ((c % 2) == 1) ? i_mode1 : i_mode0;
        assign w_top  = top_of(w_mode);
        assign w_idx  = r_phase[c] & w_top;
        assign w_pat  = pattern_of(w_mode, w_idx);
        assign w_sel  = i_cmd.visit && (i_cmd.chan == CH_W'(c));
        assign w_hit  = i_cmd.apply && (i_unit == CH_W'(c));

        always_comb begin
            if (!r_dir[c]) begin
                w_nidx = (w_idx == w_top) ? 3'd0 : w_idx + 3'd1;
            end else begin
                w_nidx = (w_idx == 3'd0) ? w_top : w_idx - 3'd1;
            end
        end

        assign w_step[c]  = (r_ticks[c] >= r_period[c]) && (r_rem[c] != 32'd0);
        assign w_coils[c] = w_step[c] ? w_pat : r_hold[c];
        // steps left after this tick
        assign w_busy[c]  = w_step[c] ? (r_rem[c] != 32'd1) : (r_rem[c] != 32'd0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rem[c]    <= '0;
                r_ticks[c]  <= '0;
                r_period[c] <= '0;
                r_phase[c]  <= '0;
                r_dir[c]    <= 1'b0;
                r_hold[c]   <= '0;
            end else if (w_hit) begin
                case (i_func)
                    FUNC_START: begin
                        r_rem[c] <= i_step_count;
                        r_dir[c] <= i_direction;
                    end
                    FUNC_STOP:   r_rem[c]    <= '0;
                    FUNC_PERIOD: r_period[c] <= i_step_period;
                    default: ;
                endcase
            end else if (w_sel) begin
                if (w_step[c]) begin
                    r_hold[c]  <= w_pat;
                    r_phase[c] <= w_nidx;
                    r_rem[c]   <= r_rem[c] - 32'd1;
                    r_ticks[c] <= '0;
                end else if (r_ticks[c] != 32'hFFFF_FFFF) begin
                    r_ticks[c] <= r_ticks[c] + 32'd1;
                end
            end
        end
    end

    always_comb begin
        n_coils_step = 1'b0;
        n_coils      = '0;
        n_busy       = 1'b0;
        for (int c = 0; c < MOTORS; c++) begin
            if (i_cmd.chan == CH_W'(c)) begin
                n_coils_step = w_step[c];
                n_coils      = w_coils[c];
                n_busy       = w_busy[c];
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.visit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.visit) begin
            r_out_chan  <= i_cmd.chan[0];
            r_out_coils <= n_coils;
            r_out_step  <= n_coils_step;
            r_out_busy  <= n_busy;
            r_out_last  <= (i_cmd.chan == CH_W'(MOTORS - 1));
        end
    end

    assign o_valid   = r_out_valid;
    assign o_channel = r_out_chan;
    assign o_coils   = r_out_coils;
    assign o_stepped = r_out_step;
    assign o_busy    = r_out_busy;
    assign o_last    = r_out_last;

endmodule

// ----- src/stepper_phase_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_unit
// Unipolar stepper sequencer with wave, full and half step coil tables.
// ----------------------------------------------------------------------------
// Start, stop and set-period command items are taken and give no result. A
// tick item makes one result per motor, channel 0 first, with last set on the
// final channel; the sequencer visits one channel per cycle, while the result
// side is not stalling, through a single result register, and the accept and
// one visit per channel complete before the next item is taken. The mode
// registers sit at byte address 0 (motor 0) and 4 (motor 1) and reset to full
// step; mode code 3 acts as full step.
module stepper_phase_sequencer_unit
    import sps_pkg::*;
#(
    parameter int MOTORS = 2
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sps_in_if.sink      i_in,
    sps_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] w_mode0;
    logic [1:0] w_mode1;
    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;

    sps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode0 (w_mode0),
        .o_mode1 (w_mode1)
    );

    sps_ctrl #(.MOTORS(MOTORS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_func  (i_in.func),
        .o_ready (i_in.ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    sps_dp #(.MOTORS(MOTORS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_func        (i_in.func),
        .i_unit        (i_in.unit),
        .i_step_count  (i_in.step_count),
        .i_direction   (i_in.direction),
        .i_step_period (i_in.step_period),
        .i_mode0       (w_mode0),
        .i_mode1       (w_mode1),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_channel     (o_out.channel),
        .o_coils       (o_out.coils),
        .o_stepped     (o_out.stepped),
        .o_busy        (o_out.busy_res),
        .o_last        (o_out.last)
    );

endmodule

// ----- dv/stepper_phase_sequencer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_unit_tb
// Self-checking bench: drives start/stop/period/tick items and mode register
// writes, predicts the per-channel coil results and compares every result.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer_unit_tb
    import sps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MOTORS      = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;

    localparam logic [2:0] ADDR_MODE_UNIT0 = 3'd0;
    localparam logic [2:0] ADDR_MODE_UNIT1 = 3'd4;

    // undefined mode code, behaves as full step
    localparam logic [1:0] MODE_UNDEF = 2'd3;

    localparam logic [3:0] WAVE_COILS [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [3:0] FULL_COILS [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
    localparam logic [3:0] HALF_COILS [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                              4'h4, 4'hC, 4'h8, 4'h9};

    typedef struct packed {
        logic       chan;
        logic [3:0] coils;
        logic       stepped;
        logic       busy;
        logic       last;
    } t_coil_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sps_in_if  in_if ();
    sps_out_if out_if ();

    stepper_phase_sequencer_unit #(
        .MOTORS (MOTORS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted motor state
    logic [31:0] steps_left  [MOTORS];
    logic [31:0] tick_cnt    [MOTORS];
    logic [31:0] step_ticks  [MOTORS];
    logic [2:0]  phase       [MOTORS];
    logic        ccw         [MOTORS];
    logic [3:0]  coils_held  [MOTORS];
    logic [1:0]  motor_mode  [MOTORS];

    t_coil_res coil_q [$];
    int        bad_count;
    int        cycle_cnt;
    int        in_idle_pct;
    int        out_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    function automatic void check_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            bad_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_coil_res want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (coil_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual ch %0d coils %0h",
                         $time, out_if.channel, out_if.coils);
                bad_count++;
            end else begin
                want = coil_q.pop_front();
                check_field("channel",  4'(want.chan),    4'(out_if.channel));
                check_field("coils",    want.coils,       out_if.coils);
                check_field("stepped",  4'(want.stepped), 4'(out_if.stepped));
                check_field("busy_res", 4'(want.busy),    4'(out_if.busy_res));
                check_field("last",     4'(want.last),    4'(out_if.last));
            end
        end
    end

    function automatic logic [3:0] coil_pattern(input logic [1:0] mode, input logic [2:0] idx);
        case (mode)
            MODE_WAVE: return WAVE_COILS[idx[1:0]];
            MODE_HALF: return HALF_COILS[idx];
            default:   return FULL_COILS[idx[1:0]];
        endcase
    endfunction

    // update motor state for one accepted item, queue the tick results
    function automatic void predict_item(input logic [1:0] f, input logic u,
                                         input logic [31:0] cnt, input logic dr,
                                         input logic [31:0] per);
        logic [2:0] top;
        logic [2:0] idx;
        t_coil_res  res;
        if (f == FUNC_START) begin
            steps_left[u] = cnt;
            ccw[u]        = dr;
        end else if (f == FUNC_STOP) begin
            steps_left[u] = '0;
        end else if (f == FUNC_PERIOD) begin
            step_ticks[u] = per;
        end else begin
            for (int m = 0; m < MOTORS; m++) begin
                top         = (motor_mode[m] == MODE_HALF) ? 3'd7 : 3'd3;
                res.stepped = 1'b0;
                if (tick_cnt[m] >= step_ticks[m] && steps_left[m] != 0) begin
                    idx           = phase[m] & top;
                    coils_held[m] = coil_pattern(motor_mode[m], idx);
                    if (!ccw[m])
                        phase[m] = (idx == top) ? 3'd0 : idx + 3'd1;
                    else
                        phase[m] = (idx == 3'd0) ? top : idx - 3'd1;
                    steps_left[m] = steps_left[m] - 1;
                    tick_cnt[m]   = '0;
                    res.stepped   = 1'b1;
                end else if (tick_cnt[m] != 32'hFFFF_FFFF) begin
                    tick_cnt[m] = tick_cnt[m] + 1;
                end
                res.chan  = m[0];
                res.coils = coils_held[m];
                res.busy  = (steps_left[m] != 0);
                res.last  = (m == MOTORS - 1);
                coil_q.push_back(res);
            end
        end
    endfunction

    task automatic send_item(input logic [1:0] f, input logic u, input logic [31:0] cnt,
                             input logic dr, input logic [31:0] per);
        if ($urandom_range(99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < in_idle_pct) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.func        <= f;
        in_if.unit        <= u;
        in_if.step_count  <= cnt;
        in_if.direction   <= dr;
        in_if.step_period <= per;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_item(f, u, cnt, dr, per);
    endtask

    task automatic tick();
        send_item(FUNC_TICK, 1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                  $urandom);
    endtask

    // block is idle once all results are back and the last channel visit is over
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (coil_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [2:0] addr, input logic [1:0] m);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {30'($urandom), m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        motor_mode[addr[2]] = m;
        // read back
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== 32'(m)) begin
            $display("%0t: mode readback mismatch at %0d: expected %0h, actual %0h",
                     $time, addr, m, prdata);
            bad_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_state();
        tick();
    endtask

    // full-step moves, period handling, stop and zero-count start
    task automatic test_moves();
        send_item(FUNC_START,  1'b0, 32'd3,          1'b0, $urandom);
        send_item(FUNC_START,  1'b1, 32'hFFFF_FFFF,  1'b1, $urandom);
        tick();
        tick();
        send_item(FUNC_PERIOD, 1'b1, $urandom, 1'b0, 32'hFFFF_FFFF);
        tick();
        tick();
        send_item(FUNC_STOP,   1'b1, $urandom, 1'b1, $urandom);
        send_item(FUNC_START,  1'b0, 32'd0,    1'b1, $urandom);
        tick();
        send_item(FUNC_PERIOD, 1'b0, $urandom, 1'b1, 32'd2);
        // tick counter keeps running across the start
        send_item(FUNC_START,  1'b0, 32'd4,    1'b1, $urandom);
        tick();
        tick();
        tick();
    endtask

    // each table, undefined mode code and a mode change in the middle of a move
    task automatic test_modes();
        drain_results();
        set_mode(ADDR_MODE_UNIT0, MODE_HALF);
        set_mode(ADDR_MODE_UNIT1, MODE_WAVE);
        send_item(FUNC_PERIOD, 1'b0, $urandom, 1'b0, 32'd0);
        send_item(FUNC_PERIOD, 1'b1, $urandom, 1'b0, 32'd0);
        send_item(FUNC_START,  1'b0, 32'd12,   1'b0, $urandom);
        send_item(FUNC_START,  1'b1, 32'd12,   1'b1, $urandom);
        repeat (3) tick();
        drain_results();
        set_mode(ADDR_MODE_UNIT0, MODE_FULL);
        set_mode(ADDR_MODE_UNIT1, MODE_UNDEF);
        repeat (2) tick();
        drain_results();
        set_mode(ADDR_MODE_UNIT0, MODE_WAVE);
        set_mode(ADDR_MODE_UNIT1, MODE_HALF);
        repeat (2) tick();
    endtask

    task automatic send_random_item();
        int          pick;
        logic [1:0]  f;
        logic [31:0] cnt;
        logic [31:0] per;
        pick = $urandom_range(99);
        f    = (pick < 55) ? FUNC_TICK : (pick < 75) ? FUNC_START :
               (pick < 83) ? FUNC_STOP : FUNC_PERIOD;
        pick = $urandom_range(99);
        cnt  = (pick < 70) ? $urandom_range(1, 20) : (pick < 80) ? 32'd0 : $urandom;
        pick = $urandom_range(99);
        per  = (pick < 70) ? $urandom_range(0, 4) : (pick < 85) ? $urandom_range(5, 30)
                                                                : $urandom;
        send_item(f, 1'($urandom_range(1)), cnt, 1'($urandom_range(1)), per);
    endtask

    task automatic test_random(input int in_pct, input int out_pct);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        repeat (3) begin
            repeat (160) send_random_item();
            drain_results();
            set_mode(ADDR_MODE_UNIT0, 2'($urandom_range(3)));
            set_mode(ADDR_MODE_UNIT1, 2'($urandom_range(3)));
        end
    endtask

    initial begin
        bad_count         = 0;
        cycle_cnt         = 0;
        in_idle_pct       = 0;
        out_idle_pct      = 0;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.func        = FUNC_TICK;
        in_if.unit        = 1'b0;
        in_if.step_count  = '0;
        in_if.direction   = 1'b0;
        in_if.step_period = '0;
        out_if.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        for (int m = 0; m < MOTORS; m++) begin
            steps_left[m] = '0;
            tick_cnt[m]   = '0;
            step_ticks[m] = '0;
            phase[m]      = '0;
            ccw[m]        = 1'b0;
            coils_held[m] = '0;
            motor_mode[m] = MODE_FULL;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_moves();
        test_modes();
        drain_results();
        test_random(22, 51);
        test_random(51, 22);
        test_random(0, 0);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (bad_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
